// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on clk, off while reset is low
`define EIM_ASSERT_IMP(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("eim check failed");

// next-cycle implication
`define EIM_ASSERT_NXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("eim check failed");

`endif

// ===== sv/eim_pkg.sv =====
// types and codes for the extent interval map
// no dependencies
package eim_pkg;

	localparam logic [2:0] OP_INSERT      = 3'd0;
	localparam logic [2:0] OP_MATCH_FIRST = 3'd1;
	localparam logic [2:0] OP_MATCH_ALL   = 3'd2;
	localparam logic [2:0] OP_WALK        = 3'd3;
	localparam logic [2:0] OP_CLEAR       = 3'd4;

	localparam logic [2:0] KIND_EXTENT   = 3'd0;
	localparam logic [2:0] KIND_HOLE     = 3'd1;
	localparam logic [2:0] KIND_NO_MATCH = 3'd2;
	localparam logic [2:0] KIND_INSERTED = 3'd3;
	localparam logic [2:0] KIND_FULL     = 3'd4;

	localparam int RESULT_CAP = 32;
	localparam int N_W = $clog2(RESULT_CAP + 1);
	localparam logic [31:0] HOLE_FLASH = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] span_start;
		logic [31:0] span_end;
		logic [31:0] flash_addr;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] out_start;
		logic [31:0] out_end;
		logic [31:0] out_flash;
		logic [31:0] out_offset;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] s;
		logic [31:0] e;
		logic [31:0] f;
	} entry_t;

	typedef enum logic [3:0] {
		CMD_NONE, CMD_LOAD, CMD_CLEAR, CMD_MATCH, CMD_WHOLE, CMD_WENT,
		CMD_INS0, CMD_INS1, CMD_INS2, CMD_INS_END, CMD_FLUSH
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD, ST_EV, ST_WH, ST_WE, ST_I0, ST_I1, ST_I2, ST_IEND, ST_FLUSH
	} state_t;

	typedef struct packed {
		logic at_end;
		logic stop;
		logic empty;
	} stat_t;

endpackage

// ===== sv/extent_interval_map.sv =====
// channel   | signals                 | accepted when
// ----------+-------------------------+----------------------------
// request   | start, req              | start high while busy low
// result    | strobe, result          | each cycle strobe is high
//
// scans the table one entry per pass: each pass reads the entry, then match
// tests it, walk emits the hole before it and the entry, insert rewrites it.
// a double-banked ram holds the table: insert rebuilds it into the idle bank.
// clear empties the table and busy stays low. reset empties the table at once.
// results cannot be stalled; each one is shown for a single cycle.
// depends on eim_pkg, eim_ctrl, eim_dp
module extent_interval_map #(
	parameter int MAX_EXTENTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  eim_pkg::req_t  req,
	output logic           busy,
	output logic           strobe,
	output eim_pkg::rsp_t  result
);
	import eim_pkg::*;

	cmd_t cmd;
	stat_t status;

	eim_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(req.op),
		.status(status), .cmd(cmd), .busy(busy)
	);

	eim_dp #(.MAX_EXTENTS(MAX_EXTENTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd),
		.status(status), .result(result), .strobe(strobe)
	);
endmodule

// ===== sv/eim_ram.sv =====
// generic single-write, single-read ram with registered read
// no dependencies
module eim_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/eim_ctrl.sv =====
// controller state machine for the extent interval map
// depends on eim_pkg
module eim_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    op,
	input  eim_pkg::stat_t status,
	output eim_pkg::cmd_t  cmd,
	output logic          busy
);
	import eim_pkg::*;

	state_t state_q, state_d;
	logic [2:0] op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_INSERT;
		end else begin
			state_q <= state_d;
			if (start && state_q == ST_IDLE) begin
				op_q <= op;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = CMD_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (op) inside
						OP_INSERT, OP_MATCH_FIRST, OP_MATCH_ALL, OP_WALK: begin
							cmd = CMD_LOAD;
							state_d = ST_RD;
						end
						OP_CLEAR: cmd = CMD_CLEAR;
						default: cmd = CMD_NONE;
					endcase
				end
			end
			ST_RD: begin
				if (op_q == OP_INSERT) begin
					state_d = (status.empty || status.at_end) ? ST_IEND : ST_I0;
				end else if (status.stop || status.at_end) begin
					state_d = ST_FLUSH;
				end else if (op_q == OP_WALK) begin
					state_d = ST_WH;
				end else begin
					state_d = ST_EV;
				end
			end
			ST_EV: begin
				cmd = CMD_MATCH;
				state_d = ST_RD;
			end
			ST_WH: begin
				cmd = CMD_WHOLE;
				state_d = ST_WE;
			end
			ST_WE: begin
				cmd = CMD_WENT;
				state_d = ST_RD;
			end
			ST_I0: begin
				cmd = CMD_INS0;
				state_d = ST_I1;
			end
			ST_I1: begin
				cmd = CMD_INS1;
				state_d = ST_I2;
			end
			ST_I2: begin
				cmd = CMD_INS2;
				state_d = ST_RD;
			end
			ST_IEND: begin
				cmd = CMD_INS_END;
				state_d = ST_IDLE;
			end
			ST_FLUSH: begin
				cmd = CMD_FLUSH;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ===== sv/eim_dp.sv =====
// datapath: double-banked extent table, scan index, trim logic, result holding
// depends on eim_pkg and eim_ram
module eim_dp #(
	parameter int MAX_EXTENTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  eim_pkg::req_t  req,
	input  eim_pkg::cmd_t  cmd,
	output eim_pkg::stat_t status,
	output eim_pkg::rsp_t  result,
	output logic           strobe
);
	import eim_pkg::*;

	localparam int AW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int NW = $clog2(2 * MAX_EXTENTS + 2);

	req_t req_q;
	logic [31:0] fmax_q, last_q;
	logic [CW-1:0] i_q, cnt_q;
	logic [NW-1:0] np_q;
	logic placed_q, bank_q, stop_q, pend_v_q, strobe_q;
	logic [N_W-1:0] n_q;
	rsp_t pend_q, out_q;

	entry_t rd0, rd1, ent, wdata, slot0_d, slot2_d, new_d;
	logic wr_en, we0, we1;
	logic [NW-1:0] wslot;
	logic [31:0] as, ae, fl;
	logic disj_lo, disj_hi, ovl, slot0, slot2, wr_ok;
	logic lhit, shit, is_hole, act, prod, set_stop;
	logic [31:0] ps, pe, pf, rb, rl, off;
	logic [2:0] pkind;
	rsp_t prod_r, flush_r;

	assign as = req_q.span_start;
	assign ae = req_q.span_end;
	assign fl = req_q.flash_addr;
	assign ent = bank_q ? rd1 : rd0;

	// insert trimming of one stored entry
	assign disj_lo = ent.e <= as;
	assign disj_hi = ent.s >= ae;
	assign ovl = !disj_lo && !disj_hi;
	assign slot0 = disj_lo || (ovl && ent.s < as);
	assign slot2 = disj_hi || (ovl && ent.e > ae);
	assign slot0_d = disj_lo ? ent : entry_t'{s: ent.s, e: as, f: ent.f};
	assign slot2_d = disj_hi ? ent : entry_t'{s: ae, e: ent.e, f: ent.f + (ae - ent.s)};
	assign new_d = '{s: as, e: ae, f: fl};
	assign wslot = np_q + NW'(placed_q);
	assign wr_ok = wslot < NW'(MAX_EXTENTS);

	always_comb begin
		wr_en = 1'b0;
		wdata = new_d;
		unique case (cmd)
			CMD_INS0: begin
				wr_en = slot0;
				wdata = slot0_d;
			end
			CMD_INS1: wr_en = slot2 && !placed_q;
			CMD_INS2: begin
				wr_en = slot2;
				wdata = slot2_d;
			end
			CMD_INS_END: wr_en = !placed_q && !status.empty;
			default: wr_en = 1'b0;
		endcase
	end

	// writes always go to the inactive bank
	assign we1 = wr_en && wr_ok && !bank_q;
	assign we0 = wr_en && wr_ok && bank_q;

	eim_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_EXTENTS)) u_bank0 (
		.clk(clk), .we(we0), .waddr(wslot[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd0)
	);
	eim_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_EXTENTS)) u_bank1 (
		.clk(clk), .we(we1), .waddr(wslot[AW-1:0]), .wdata(wdata),
		.raddr(i_q[AW-1:0]), .rdata(rd1)
	);

	// match and walk evaluation
	assign lhit = as < ent.e && ent.s < ae;
	assign shit = ent.f < fmax_q && fl < ent.f + (ent.e - ent.s);
	assign is_hole = (cmd == CMD_WHOLE);
	assign ps = is_hole ? last_q : ent.s;
	assign pe = is_hole ? ent.s : ent.e;
	assign pf = is_hole ? HOLE_FLASH : ent.f;
	assign pkind = is_hole ? KIND_HOLE : KIND_EXTENT;
	assign act = is_hole ? (last_q < ent.s) : 1'b1;
	assign rb = (ps < as) ? as : ps;
	assign off = (ps < as) ? as - ps : 32'd0;
	assign rl = (pe > ae) ? ae : pe;

	always_comb begin
		prod = 1'b0;
		set_stop = 1'b0;
		prod_r = '{kind: KIND_EXTENT, out_start: ent.s, out_end: ent.e,
			out_flash: ent.f, out_offset: 32'd0, last: 1'b0};
		if (!stop_q) begin
			unique case (cmd)
				CMD_MATCH: begin
					if (req_q.op == OP_MATCH_FIRST) begin
						prod = lhit && shit;
						set_stop = lhit && shit;
					end else if (ent.s >= ae) begin
						set_stop = 1'b1;
					end else begin
						prod = as < ent.e && shit;
					end
				end
				CMD_WHOLE, CMD_WENT: begin
					if (act) begin
						if (ps >= ae) begin
							set_stop = 1'b1;
						end else if (pe > as) begin
							prod = 1'b1;
							prod_r = '{kind: pkind, out_start: rb - as, out_end: rl - as,
								out_flash: pf, out_offset: off, last: 1'b0};
						end
					end
				end
				default: prod = 1'b0;
			endcase
		end
	end

	// final result of a scan: the held one, or no match
	always_comb begin
		if (pend_v_q) begin
			flush_r = pend_q;
		end else begin
			flush_r = '{kind: KIND_NO_MATCH, out_start: 32'd0, out_end: 32'd0,
				out_flash: 32'd0, out_offset: 32'd0, last: 1'b0};
		end
		flush_r.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			cnt_q <= '0;
			np_q <= '0;
			placed_q <= 1'b0;
			bank_q <= 1'b0;
			stop_q <= 1'b0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
			n_q <= '0;
			last_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (cmd)
				CMD_LOAD: begin
					i_q <= '0;
					np_q <= '0;
					placed_q <= 1'b0;
					stop_q <= 1'b0;
					pend_v_q <= 1'b0;
					n_q <= '0;
					last_q <= '0;
				end
				CMD_CLEAR: cnt_q <= '0;
				CMD_INS0: begin
					if (slot0) np_q <= np_q + NW'(1);
				end
				CMD_INS1: begin
					if (slot2) placed_q <= 1'b1;
				end
				CMD_INS2: begin
					if (slot2) np_q <= np_q + NW'(1);
					i_q <= i_q + CW'(1);
				end
				CMD_INS_END: begin
					strobe_q <= 1'b1;
					if (!status.empty && np_q < NW'(MAX_EXTENTS)) begin
						bank_q <= !bank_q;
						cnt_q <= CW'(np_q + NW'(1));
					end
				end
				CMD_MATCH, CMD_WENT: i_q <= i_q + CW'(1);
				default: ;
			endcase
			if (cmd == CMD_WHOLE || cmd == CMD_WENT) begin
				if (!stop_q && act && ps < ae) last_q <= pe;
			end
			if (set_stop) stop_q <= 1'b1;
			// hold one result back so the final one can carry last
			if (prod) begin
				if (pend_v_q) strobe_q <= 1'b1;
				pend_v_q <= 1'b1;
				n_q <= n_q + N_W'(1);
				if (n_q + N_W'(1) == N_W'(RESULT_CAP)) stop_q <= 1'b1;
			end
			if (cmd == CMD_FLUSH) begin
				strobe_q <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			req_q <= req;
			fmax_q <= req.flash_addr + (req.span_end - req.span_start);
		end
		if (prod) begin
			pend_q <= prod_r;
			out_q <= pend_q;
		end
		if (cmd == CMD_FLUSH) begin
			out_q <= flush_r;
		end
		if (cmd == CMD_INS_END) begin
			out_q <= '{kind: (!status.empty && np_q >= NW'(MAX_EXTENTS)) ? KIND_FULL
					: KIND_INSERTED,
				out_start: as, out_end: ae, out_flash: fl, out_offset: 32'd0, last: 1'b1};
		end
	end

	assign status.at_end = i_q >= cnt_q;
	assign status.stop = stop_q;
	assign status.empty = as >= ae;
	assign result = out_q;
	assign strobe = strobe_q;
endmodule

// ===== sv/eim_checker.sv =====
// port-level checks on result sequencing of the extent interval map
// depends on eim_pkg and assert_macros.svh
`include "assert_macros.svh"

module eim_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          busy,
	input logic          strobe,
	input eim_pkg::rsp_t result
);
	import eim_pkg::*;

	`EIM_ASSERT_IMP(a_res_in_op, clk, arst_n, strobe, $past(busy))
	`EIM_ASSERT_IMP(a_end_has_last, clk, arst_n, $fell(busy), strobe && result.last)
	`EIM_ASSERT_NXT(a_more_follows, clk, arst_n, strobe && !result.last, busy)
	`EIM_ASSERT_IMP(a_last_ends, clk, arst_n, strobe && result.last, !busy)
endmodule

bind extent_interval_map eim_checker u_eim_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy),
	.strobe(strobe), .result(result)
);

// ===== dv/extent_interval_map_test.sv =====
// self-checking testbench for extent_interval_map: directed table then random requests
// keeps its own copy of the extent table to predict every result
// depends on eim_pkg and the extent_interval_map rtl
module extent_interval_map_test;
	import eim_pkg::*;

	localparam int TBL_DEPTH  = 16;
	localparam int RAND_ITEMS = 340;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN      = 120;
	localparam logic [2:0] OP_SPARE5 = 3'd5;
	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	typedef struct {
		logic [2:0]  op;
		logic [31:0] s;
		logic [31:0] e;
		logic [31:0] f;
		int          rpt;
		bit          typed;
		logic [2:0]  kind;
	} row_t;

	localparam int N_ROWS = 24;
	row_t dir_rows [N_ROWS] = '{
		'{OP_MATCH_FIRST, 0, '1, 0, 1, 1, KIND_NO_MATCH},
		'{OP_WALK, 0, 100, 0, 1, 1, KIND_NO_MATCH},
		'{OP_MATCH_ALL, 0, '1, '1, 1, 1, KIND_NO_MATCH},
		'{OP_INSERT, 100, 200, 1000, 1, 1, KIND_INSERTED},
		'{OP_INSERT, 50, 50, 7, 1, 1, KIND_INSERTED},
		'{OP_INSERT, 300, 200, 7, 1, 1, KIND_INSERTED},
		'{OP_INSERT, 32'hFFFF_FF00, '1, 32'hFFFF_FFF0, 1, 1, KIND_INSERTED},
		'{OP_INSERT, 150, 160, 5, 1, 0, KIND_INSERTED},
		'{OP_INSERT, 90, 120, 7, 1, 0, KIND_INSERTED},
		'{OP_INSERT, 155, 300, 40, 1, 0, KIND_INSERTED},
		'{OP_MATCH_FIRST, 0, '1, 0, 1, 0, KIND_EXTENT},
		'{OP_MATCH_ALL, 0, '1, 0, 1, 0, KIND_EXTENT},
		'{OP_WALK, 0, '1, 0, 1, 0, KIND_EXTENT},
		'{OP_WALK, 120, 32'hFFFF_FF80, 0, 1, 0, KIND_EXTENT},
		'{OP_WALK, 200, 100, 0, 1, 0, KIND_EXTENT},
		'{OP_SPARE5, 1, 2, 3, 1, 0, KIND_EXTENT},
		'{OP_SPARE6, 1, 2, 3, 1, 0, KIND_EXTENT},
		'{OP_SPARE7, 1, 2, 3, 1, 0, KIND_EXTENT},
		'{OP_CLEAR, 0, 0, 0, 1, 0, KIND_EXTENT},
		'{OP_INSERT, 10, 14, 0, TBL_DEPTH, 0, KIND_EXTENT},
		'{OP_INSERT, 12, 13, 77, 1, 1, KIND_FULL},
		'{OP_WALK, 0, '1, 0, 1, 0, KIND_EXTENT},
		'{OP_MATCH_ALL, 0, '1, 0, 1, 0, KIND_EXTENT},
		'{OP_INSERT, 0, '1, 9, 1, 1, KIND_INSERTED}
	};

	logic clk, arst_n, start, busy, strobe;
	req_t req;
	rsp_t result;

	extent_interval_map dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .strobe(strobe), .result(result)
	);

	// shadow copy of the extent table
	logic [31:0] ext_s [TBL_DEPTH];
	logic [31:0] ext_e [TBL_DEPTH];
	logic [31:0] ext_f [TBL_DEPTH];
	int ext_n;

	rsp_t pend[$];
	rsp_t expected_rsp[$];
	int errors;
	int burst;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	task automatic report(string msg);
		$display("mismatch @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void add_rsp(logic [2:0] k, logic [31:0] s, logic [31:0] e,
			logic [31:0] f, logic [31:0] o);
		if (pend.size() < RESULT_CAP)
			pend.push_back('{k, s, e, f, o, 1'b0});
	endfunction

	function automatic void insert_extent(logic [31:0] as, logic [31:0] ae, logic [31:0] af);
		logic [31:0] ps [TBL_DEPTH + 2];
		logic [31:0] pe [TBL_DEPTH + 2];
		logic [31:0] pf [TBL_DEPTH + 2];
		int np, j;
		bit placed;
		np = 0;
		j = 0;
		placed = 0;
		if (as >= ae) begin
			add_rsp(KIND_INSERTED, as, ae, af, 0);
			return;
		end
		for (int i = 0; i < ext_n; i++) begin
			if (ext_e[i] <= as || ext_s[i] >= ae) begin
				ps[np] = ext_s[i]; pe[np] = ext_e[i]; pf[np] = ext_f[i]; np++;
			end else begin
				if (ext_s[i] < as) begin
					ps[np] = ext_s[i]; pe[np] = as; pf[np] = ext_f[i]; np++;
				end
				// tail piece keeps its flash position relative to the old start
				if (ext_e[i] > ae) begin
					ps[np] = ae; pe[np] = ext_e[i]; pf[np] = ext_f[i] + (ae - ext_s[i]); np++;
				end
			end
		end
		if (np + 1 > TBL_DEPTH) begin
			add_rsp(KIND_FULL, as, ae, af, 0);
			return;
		end
		for (int k = 0; k < np; k++) begin
			if (!placed && ps[k] >= ae) begin
				ext_s[j] = as; ext_e[j] = ae; ext_f[j] = af; j++;
				placed = 1;
			end
			ext_s[j] = ps[k]; ext_e[j] = pe[k]; ext_f[j] = pf[k]; j++;
		end
		if (!placed) begin
			ext_s[j] = as; ext_e[j] = ae; ext_f[j] = af; j++;
		end
		ext_n = j;
		add_rsp(KIND_INSERTED, as, ae, af, 0);
	endfunction

	function automatic void walk_range(logic [31:0] base, logic [31:0] lim);
		logic [31:0] prev, ps, pe, pf, rb, rl, off;
		logic [2:0] k;
		bit done;
		prev = 0;
		done = 0;
		for (int i = 0; i < ext_n && !done; i++) begin
			for (int ph = 0; ph < 2 && !done; ph++) begin
				if (ph == 0 && !(prev < ext_s[i]))
					continue;
				if (ph == 0) begin
					ps = prev; pe = ext_s[i]; pf = HOLE_FLASH; k = KIND_HOLE;
				end else begin
					ps = ext_s[i]; pe = ext_e[i]; pf = ext_f[i]; k = KIND_EXTENT;
				end
				if (ps >= lim) begin
					done = 1;
				end else begin
					if (pe > base) begin
						rb = ps;
						off = 0;
						if (rb < base) begin
							off = base - rb;
							rb = base;
						end
						rl = pe > lim ? lim : pe;
						add_rsp(k, rb - base, rl - base, pf, off);
					end
					prev = pe;
				end
			end
		end
	endfunction

	function automatic bit flash_hit(int i, logic [31:0] fl, logic [31:0] fmax);
		logic [31:0] len, top;
		len = ext_e[i] - ext_s[i];
		top = ext_f[i] + len;
		return ext_f[i] < fmax && fl < top;
	endfunction

	// fills pend with the results of one request and updates the shadow table
	function automatic void predict_results(req_t r);
		logic [31:0] fmax;
		fmax = r.flash_addr + (r.span_end - r.span_start);
		pend.delete();
		case (r.op)
			OP_INSERT: insert_extent(r.span_start, r.span_end, r.flash_addr);
			OP_MATCH_FIRST: begin
				for (int i = 0; i < ext_n; i++)
					if (r.span_start < ext_e[i] && ext_s[i] < r.span_end
							&& flash_hit(i, r.flash_addr, fmax)) begin
						add_rsp(KIND_EXTENT, ext_s[i], ext_e[i], ext_f[i], 0);
						break;
					end
			end
			OP_MATCH_ALL: begin
				for (int i = 0; i < ext_n; i++) begin
					if (ext_s[i] >= r.span_end)
						break;
					if (r.span_start < ext_e[i] && flash_hit(i, r.flash_addr, fmax))
						add_rsp(KIND_EXTENT, ext_s[i], ext_e[i], ext_f[i], 0);
				end
			end
			OP_WALK: walk_range(r.span_start, r.span_end);
			OP_CLEAR: ext_n = 0;
			default: ;
		endcase
		if (pend.size() == 0 && (r.op == OP_MATCH_FIRST || r.op == OP_MATCH_ALL
				|| r.op == OP_WALK))
			add_rsp(KIND_NO_MATCH, 0, 0, 0, 0);
		if (pend.size() > 0)
			pend[pend.size() - 1].last = 1'b1;
	endfunction

	// drives one request, waits for acceptance, then idles between bursts
	task automatic send(req_t r, bit typed, logic [2:0] tk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		predict_results(r);
		if (typed)
			pend = '{'{tk, (tk == KIND_NO_MATCH) ? 32'd0 : r.span_start,
				(tk == KIND_NO_MATCH) ? 32'd0 : r.span_end,
				(tk == KIND_NO_MATCH) ? 32'd0 : r.flash_addr, 32'd0, 1'b1}};
		expected_rsp = {expected_rsp, pend};
		burst--;
		if (burst <= 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 6);
		end
	endtask

	function automatic logic [31:0] rand_addr();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 32'hFFFF_FF00 + $urandom_range(0, 255);
			default: return $urandom_range(0, 400);
		endcase
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int pick;
		pick = $urandom_range(0, 99);
		r.span_start = rand_addr();
		r.span_end = ($urandom_range(0, 9) == 0) ? rand_addr()
			: r.span_start + $urandom_range(1, 80);
		r.flash_addr = rand_addr();
		if (pick < 42)
			r.op = OP_INSERT;
		else if (pick < 57)
			r.op = OP_MATCH_FIRST;
		else if (pick < 72)
			r.op = OP_MATCH_ALL;
		else if (pick < 94)
			r.op = OP_WALK;
		else if (pick < 97)
			r.op = OP_CLEAR;
		else
			r.op = 3'($urandom_range(OP_SPARE5, OP_SPARE7));
		return r;
	endfunction

	task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		rsp_t w;
		if (arst_n && strobe) begin
			if (expected_rsp.size() == 0) begin
				report($sformatf("unexpected result %p", result));
			end else begin
				w = expected_rsp.pop_front();
				cmp_field("kind", 32'(result.kind), 32'(w.kind));
				cmp_field("out_start", result.out_start, w.out_start);
				cmp_field("out_end", result.out_end, w.out_end);
				cmp_field("out_flash", result.out_flash, w.out_flash);
				cmp_field("out_offset", result.out_offset, w.out_offset);
				cmp_field("last", 32'(result.last), 32'(w.last));
			end
		end
	end

	// watchdog on cycles with neither a request nor a result taken
	int idle_cycles;
	always @(posedge clk) begin
		if ((start && !busy) || strobe || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		req_t r;
		errors = 0;
		ext_n = 0;
		burst = 3;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[n]) begin
			for (int k = 0; k < dir_rows[n].rpt; k++) begin
				r.op = dir_rows[n].op;
				r.span_start = dir_rows[n].s + 10 * k;
				r.span_end = dir_rows[n].e + 10 * k;
				r.flash_addr = dir_rows[n].f + 16 * k;
				send(r, dir_rows[n].typed, dir_rows[n].kind);
			end
		end
		repeat (RAND_ITEMS)
			send(rand_req(), 1'b0, KIND_EXTENT);
		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
